// ===== hdl/geodetic_to_ecef_macros.svh =====
// Assertion macros for the geodetic to ECEF converter.
`ifndef GEODETIC_TO_ECEF_MACROS_SVH
`define GEODETIC_TO_ECEF_MACROS_SVH

// Combinational or same-cycle implication, checked on every rising edge out of reset.
`define G2E_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the next one.
`define G2E_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/g2e_pkg.sv =====
// Package with the constants, types and constant functions of the geodetic to ECEF converter.
package g2e_pkg;

	localparam int CORDIC_CAP = 62;
	localparam int MAG_W      = 30;

	localparam logic signed [63:0] ONE_Q61       = 64'sh2000000000000000;
	localparam logic signed [63:0] THREE_Q61     = 64'sh6000000000000000;
	localparam logic signed [63:0] GAIN_Q61      = 64'sd1400229935014726480;
	localparam logic signed [63:0] SEMI_MAJOR_MM = 64'sd6378137000;
	localparam logic [63:0]        SAT_MAX       = 64'h7FFFFFFFFFFFFFFF;
	localparam logic [63:0]        PI_Q62        = 64'hC90FDAA22168C235;

	localparam logic signed [33:0] FULL_TURN    = 34'sd3600000000;
	localparam logic signed [33:0] HALF_TURN    = 34'sd1800000000;
	localparam logic signed [33:0] QUARTER_TURN = 34'sd900000000;

	// pi * 2^62 / full turn split into quotient and remainder
	localparam logic [63:0] QP = PI_Q62 / 64'd3600000000;
	localparam logic [63:0] RP = PI_Q62 % 64'd3600000000;

	// ceil(RP * 2^64 / full turn); exact floor for magnitudes below 2^30
	localparam logic [127:0] RP_WIDE  = {64'd0, RP};
	localparam logic [63:0]  RP_RECIP =
		64'(((RP_WIDE << 64) + 128'd3599999999) / 128'd3600000000);

	localparam logic [127:0] INV_FLAT_E9 = 128'd298257223563;
	localparam logic [127:0] F_NUM  = (128'd1 << 61) * 128'd1000000000 + INV_FLAT_E9 / 128'd2;
	localparam logic [127:0] F_WIDE = F_NUM / INV_FLAT_E9;
	localparam logic [127:0] FF_RND = (F_WIDE * F_WIDE + (128'd1 << 60)) >> 61;
	localparam logic signed [63:0] E2_Q61   = 64'(128'd2 * F_WIDE - FF_RND);
	localparam logic signed [63:0] OME2_Q61 = ONE_Q61 - E2_Q61;

	typedef logic signed [63:0] atan_tab_t [CORDIC_CAP];

	function automatic logic signed [63:0] atan_q61(input int i);
		logic signed [63:0] sum;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		logic [63:0] rem;
		int e;
		sum = '0;
		if (i == 0) begin
			return $signed((PI_Q62 + 64'd4) >> 3);
		end
		for (int k = 0; k < 32; k++) begin
			e = 62 - i - 2 * i * k;
			if (e >= 0) begin
				num = 64'd1 << e;
				den = 64'(2 * k + 1);
				quo = '0;
				rem = '0;
				for (int b = 63; b >= 0; b--) begin
					rem = {rem[62:0], num[b]};
					quo = {quo[62:0], 1'b0};
					if (rem >= den) begin
						rem = rem - den;
						quo[0] = 1'b1;
					end
				end
				if ((k & 1) != 0) begin
					sum = sum - $signed(quo);
				end else begin
					sum = sum + $signed(quo);
				end
			end
		end
		return (sum + 64'sd1) >>> 1;
	endfunction

	function automatic atan_tab_t atan_table();
		atan_tab_t t;
		for (int i = 0; i < CORDIC_CAP; i++) begin
			t[i] = atan_q61(i);
		end
		return t;
	endfunction

	localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

// ===== hdl/g2e_mulshift.sv =====
// Pipelined signed 64x64 multiply with round-to-nearest right shift and saturation.
module g2e_mulshift import g2e_pkg::*; #(
	parameter int SHIFT = 61
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	output logic signed [63:0] p
);

	logic [63:0]  ua_s1, ub_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] sum_s3;
	logic [127:0] rnd, shf;
	logic [63:0]  mag;

	always_comb begin
		rnd = sum_s3 + (128'd1 << (SHIFT - 1));
		shf = rnd >> SHIFT;
		mag = (|shf[127:63]) ? SAT_MAX : shf[63:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= a[63] ? $unsigned(-a) : $unsigned(a);
			ub_s1  <= b[63] ? $unsigned(-b) : $unsigned(b);
			neg_s1 <= a[63] ^ b[63];
			p00_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[31:0]);
			p01_s2 <= 64'(ua_s1[31:0]) * 64'(ub_s1[63:32]);
			p10_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[31:0]);
			p11_s2 <= 64'(ua_s1[63:32]) * 64'(ub_s1[63:32]);
			neg_s2 <= neg_s1;
			sum_s3 <= 128'(p00_s2) + (128'(p01_s2) << 32) + (128'(p10_s2) << 32)
				+ {p11_s2, 64'd0};
			neg_s3 <= neg_s2;
			p      <= neg_s3 ? -$signed(mag) : $signed(mag);
		end
	end

endmodule

// ===== hdl/geodetic_to_ecef.sv =====
// Top level of the WGS-84 geodetic to ECEF converter.
// Throughput: one position per cycle unless the pipeline freezes; one register stage per
// CORDIC iteration, two for the degree-to-radian step and four per multiply.
// The pipeline freezes only while its last stage and the output register are both full.
// Reset clears the valid bits and the output register's valid; data registers are not reset.
`include "geodetic_to_ecef_macros.svh"

module geodetic_to_ecef import g2e_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [30:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic signed [27:0] height_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [33:0] ecef_x,
	output logic signed [33:0] ecef_y,
	output logic signed [33:0] ecef_z
);

	localparam int NI = (CORDIC_ITERATIONS > CORDIC_CAP) ? CORDIC_CAP : CORDIC_ITERATIONS;
	localparam int ST_TRIG  = 5 + NI;
	localparam int MS_LAT   = 4;
	localparam int NEWTON   = 3;
	localparam int STEP_LEN = 3 * MS_LAT + 1;
	localparam int T_W      = 2 * MS_LAT + 1;
	localparam int T_R0     = T_W + 1;
	localparam int T_RN     = T_R0 + NEWTON * STEP_LEN;
	localparam int T_N      = T_RN + MS_LAT;
	localparam int T_NH     = T_N + 1;
	localparam int T_P      = T_N + MS_LAT + 1;
	localparam int T_OUT    = T_P + MS_LAT;
	localparam int LAT      = ST_TRIG + T_OUT;
	localparam int TD       = T_P + 1;
	localparam int HD       = ST_TRIG + T_P - 1;

	logic           en, out_take;
	logic [LAT:1]   vld_q;

	logic signed [33:0]   fa [2];
	logic signed [33:0]   fb [2];
	logic signed [33:0]   fc [2];
	logic [1:0]           fflip;
	logic [MAG_W-1:0]     fm [2];

	logic [1:0]           sgn_s1, flip_s1;
	logic [MAG_W-1:0]     mag_s1 [2];

	logic [61:0]          dhi_q   [2][2];
	logic [61:0]          rlo_q   [2];
	logic [61:0]          rhi_q   [2];
	logic [93:0]          dsum    [2];
	logic [MAG_W-1:0]     dq_q    [2];
	logic                 dsgn_q  [2][2];
	logic                 dflip_q [2][2];

	logic signed [63:0]   cx_q [2][NI+1];
	logic signed [63:0]   cy_q [2][NI+1];
	logic signed [63:0]   cz_q [2][NI+1];
	logic                 cflip_q [2][NI+1];

	logic signed [63:0]   ts_q [2][TD];
	logic signed [63:0]   tc_q [2][TD];
	logic signed [27:0]   h_q [HD];

	logic signed [63:0]   s2_w, e2s_w, w_q, r0_q, w0_q;
	logic signed [63:0]   nr [NEWTON+1];
	logic signed [63:0]   nw [NEWTON];
	logic signed [63:0]   n_w, nh_q, nzm_w, nz_q, p_w, x_w, y_w, z_w;

	assign out_take = !out_valid || !out_stall;
	assign en       = out_take || !vld_q[LAT];
	assign in_stall = !en;

	// fold both angles into [-90, 90] degrees
	always_comb begin
		fa[0] = 34'(latitude);
		fa[1] = 34'(longitude);
		for (int l = 0; l < 2; l++) begin
			if (fa[l] > HALF_TURN) begin
				fb[l] = fa[l] - FULL_TURN;
			end else if (fa[l] < -HALF_TURN) begin
				fb[l] = fa[l] + FULL_TURN;
			end else begin
				fb[l] = fa[l];
			end
			if (fb[l] > QUARTER_TURN) begin
				fc[l]    = fb[l] - HALF_TURN;
				fflip[l] = 1'b1;
			end else if (fb[l] < -QUARTER_TURN) begin
				fc[l]    = fb[l] + HALF_TURN;
				fflip[l] = 1'b1;
			end else begin
				fc[l]    = fb[l];
				fflip[l] = 1'b0;
			end
			fm[l] = MAG_W'(fc[l][33] ? -fc[l] : fc[l]);
		end
	end

	// round(mag * RP / full turn) via the scaled reciprocal
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			dsum[l] = {rhi_q[l], 32'd0} + 94'(rlo_q[l]) + (94'd1 << 63);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-1:1], in_valid};
			end
			if (out_take) begin
				out_valid <= vld_q[LAT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take) begin
			ecef_x <= x_w[33:0];
			ecef_y <= y_w[33:0];
			ecef_z <= z_w[33:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				sgn_s1[l]  <= fc[l][33];
				flip_s1[l] <= fflip[l];
				mag_s1[l]  <= fm[l];

				// radians = mag * pi / 180 deg, as mag*QP + (mag*RP + half) / full turn
				dhi_q[l][0]   <= 62'(mag_s1[l]) * 62'(QP[31:0]);
				rlo_q[l]      <= 62'(mag_s1[l]) * 62'(RP_RECIP[31:0]);
				rhi_q[l]      <= 62'(mag_s1[l]) * 62'(RP_RECIP[63:32]);
				dsgn_q[l][0]  <= sgn_s1[l];
				dflip_q[l][0] <= flip_s1[l];

				dhi_q[l][1]   <= dhi_q[l][0];
				dq_q[l]       <= dsum[l][93:64];
				dsgn_q[l][1]  <= dsgn_q[l][0];
				dflip_q[l][1] <= dflip_q[l][0];

				cx_q[l][0] <= GAIN_Q61;
				cy_q[l][0] <= '0;
				cz_q[l][0] <= dsgn_q[l][1]
					? -$signed(64'(dhi_q[l][1]) + 64'(dq_q[l]))
					: $signed(64'(dhi_q[l][1]) + 64'(dq_q[l]));
				cflip_q[l][0] <= dflip_q[l][1];
				for (int i = 0; i < NI; i++) begin
					if (!cz_q[l][i][63]) begin
						cx_q[l][i+1] <= cx_q[l][i] - (cy_q[l][i] >>> i);
						cy_q[l][i+1] <= cy_q[l][i] + (cx_q[l][i] >>> i);
						cz_q[l][i+1] <= cz_q[l][i] - ATAN_TAB[i];
					end else begin
						cx_q[l][i+1] <= cx_q[l][i] + (cy_q[l][i] >>> i);
						cy_q[l][i+1] <= cy_q[l][i] - (cx_q[l][i] >>> i);
						cz_q[l][i+1] <= cz_q[l][i] + ATAN_TAB[i];
					end
					cflip_q[l][i+1] <= cflip_q[l][i];
				end

				ts_q[l][0] <= cflip_q[l][NI] ? -cy_q[l][NI] : cy_q[l][NI];
				tc_q[l][0] <= cflip_q[l][NI] ? -cx_q[l][NI] : cx_q[l][NI];
				for (int k = 1; k < TD; k++) begin
					ts_q[l][k] <= ts_q[l][k-1];
					tc_q[l][k] <= tc_q[l][k-1];
				end
			end

			h_q[0] <= height_mm;
			for (int k = 1; k < HD; k++) begin
				h_q[k] <= h_q[k-1];
			end

			w_q  <= ONE_Q61 - e2s_w;
			r0_q <= (THREE_Q61 - w_q + 64'sd1) >>> 1;
			w0_q <= w_q;
			nh_q <= n_w + (64'(h_q[ST_TRIG+T_N-1]) <<< 24);
			nz_q <= nzm_w + (64'(h_q[ST_TRIG+T_P-2]) <<< 24);
		end
	end

	g2e_mulshift #(.SHIFT(61)) u_s2 (
		.clk(clk), .en(en), .a(ts_q[0][0]), .b(ts_q[0][0]), .p(s2_w)
	);

	g2e_mulshift #(.SHIFT(61)) u_e2s (
		.clk(clk), .en(en), .a(E2_Q61), .b(s2_w), .p(e2s_w)
	);

	assign nr[0] = r0_q;
	assign nw[0] = w0_q;

	// Newton steps for 1/sqrt(w): r' = r * (3 - w r^2) / 2
	for (genvar j = 0; j < NEWTON; j++) begin : g_newton
		logic signed [63:0] wd_q [STEP_LEN];
		logic signed [63:0] rd_q [2*MS_LAT+1];
		logic signed [63:0] t_w, wr2_w, b_q;

		always_ff @(posedge clk) begin
			if (en) begin
				wd_q[0] <= nw[j];
				for (int k = 1; k < STEP_LEN; k++) begin
					wd_q[k] <= wd_q[k-1];
				end
				rd_q[0] <= nr[j];
				for (int k = 1; k < 2 * MS_LAT + 1; k++) begin
					rd_q[k] <= rd_q[k-1];
				end
				b_q <= THREE_Q61 - wr2_w;
			end
		end

		g2e_mulshift #(.SHIFT(61)) u_rr (
			.clk(clk), .en(en), .a(nr[j]), .b(nr[j]), .p(t_w)
		);

		g2e_mulshift #(.SHIFT(61)) u_wt (
			.clk(clk), .en(en), .a(wd_q[MS_LAT-1]), .b(t_w), .p(wr2_w)
		);

		g2e_mulshift #(.SHIFT(62)) u_rb (
			.clk(clk), .en(en), .a(rd_q[2*MS_LAT]), .b(b_q), .p(nr[j+1])
		);

		if (j < NEWTON - 1) begin : g_wnext
			assign nw[j+1] = wd_q[STEP_LEN-1];
		end
	end

	g2e_mulshift #(.SHIFT(37)) u_n (
		.clk(clk), .en(en), .a(SEMI_MAJOR_MM), .b(nr[NEWTON]), .p(n_w)
	);

	g2e_mulshift #(.SHIFT(61)) u_nz (
		.clk(clk), .en(en), .a(n_w), .b(OME2_Q61), .p(nzm_w)
	);

	g2e_mulshift #(.SHIFT(61)) u_p (
		.clk(clk), .en(en), .a(nh_q), .b(tc_q[0][T_NH]), .p(p_w)
	);

	g2e_mulshift #(.SHIFT(85)) u_x (
		.clk(clk), .en(en), .a(p_w), .b(tc_q[1][T_P]), .p(x_w)
	);

	g2e_mulshift #(.SHIFT(85)) u_y (
		.clk(clk), .en(en), .a(p_w), .b(ts_q[1][T_P]), .p(y_w)
	);

	g2e_mulshift #(.SHIFT(85)) u_z (
		.clk(clk), .en(en), .a(nz_q), .b(ts_q[0][T_P]), .p(z_w)
	);

	`G2E_ASSERT_NEXT(a_freeze_holds, !en, vld_q[LAT] && $stable(vld_q), "frozen pipe moved")
	`G2E_ASSERT_NEXT(a_last_taken, vld_q[LAT] && out_take, out_valid, "result lost at output")
	`G2E_ASSERT(a_sin_bound,
		vld_q[ST_TRIG] |-> (ts_q[0][0] <= 2 * ONE_Q61 && ts_q[0][0] >= -2 * ONE_Q61),
		"sine out of range")
	`G2E_ASSERT(a_w_range, vld_q[ST_TRIG+T_W] |-> (w_q > 64'sd0 && w_q <= ONE_Q61),
		"w out of range")

endmodule

// ===== dv/geodetic_to_ecef_tb.sv =====
// Self-checking testbench for the WGS-84 geodetic to ECEF converter.
`timescale 1ns / 100ps

module geodetic_to_ecef_tb import g2e_pkg::*; ();

	localparam int CORDIC_N   = 32;
	localparam int STALL_MAX  = 5000;
	localparam int TAIL_WAIT  = 300;
	localparam int HOLD_LEN   = 600;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
	} ecef_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic signed [27:0] height_mm;
	logic               out_valid;
	logic               out_stall;
	logic signed [33:0] ecef_x;
	logic signed [33:0] ecef_y;
	logic signed [33:0] ecef_z;

	ecef_t             ecef_expected[$];
	logic signed [63:0] atan_rad[CORDIC_N];
	logic signed [63:0] flat_q61;
	logic signed [63:0] ecc2_q61;
	logic signed [63:0] one_minus_ecc2;
	int                errors;
	int                fixes_sent;
	int                fixes_checked;
	int                idle_cycles;
	int                tx_idle_en;
	int                rx_idle_en;
	int                hold_cnt;
	int                burst_cnt;

	geodetic_to_ecef #(.CORDIC_ITERATIONS(CORDIC_N)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.latitude(latitude), .longitude(longitude), .height_mm(height_mm),
		.out_valid(out_valid), .out_stall(out_stall),
		.ecef_x(ecef_x), .ecef_y(ecef_y), .ecef_z(ecef_z)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// round(a*b / 2^s), ties away from zero, saturating
	function automatic logic signed [63:0] mul_rnd(input logic signed [63:0] a,
			input logic signed [63:0] b, input int s);
		logic [127:0] ua;
		logic [127:0] ub;
		logic [127:0] pr;
		logic [63:0]  r;
		ua = {64'd0, a < 0 ? 64'(-a) : 64'(a)};
		ub = {64'd0, b < 0 ? 64'(-b) : 64'(b)};
		pr = (ua * ub + (128'd1 << (s - 1))) >> s;
		r = (pr > {64'd0, SAT_MAX}) ? SAT_MAX : pr[63:0];
		return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] arctan_pow2(input int i);
		logic signed [63:0] acc;
		logic [63:0]        term;
		longint             kk;
		if (i == 0)
			return $signed((PI_Q62 + 64'd4) >> 3);
		acc = 0;
		kk = 0;
		for (int e = 62 - i; e >= 0; e -= 2 * i) begin
			term = (64'd1 << e) / 64'(2 * kk + 1);
			acc = (kk % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
			kk++;
		end
		return (acc + 64'sd1) >>> 1;
	endfunction

	// sine and cosine in Q61 of an angle in 1e-7 degree
	task automatic angle_sin_cos(input longint deg7, output logic signed [63:0] sn,
			output logic signed [63:0] cs);
		logic               flip;
		logic [127:0]       pr;
		logic signed [63:0] zr;
		logic signed [63:0] xr;
		logic signed [63:0] yr;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		longint             v;
		flip = 1'b0;
		v = deg7;
		if (v > HALF_TURN) v -= FULL_TURN;
		if (v < -HALF_TURN) v += FULL_TURN;
		if (v > QUARTER_TURN) begin
			v -= HALF_TURN;
			flip = 1'b1;
		end else if (v < -QUARTER_TURN) begin
			v += HALF_TURN;
			flip = 1'b1;
		end
		pr = 128'(v < 0 ? -v : v) * {64'd0, PI_Q62} + 128'd1800000000;
		pr = pr / 128'd3600000000;
		zr = v < 0 ? -$signed(pr[63:0]) : $signed(pr[63:0]);
		xr = GAIN_Q61;
		yr = 0;
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (zr >= 0) begin
				xr -= dx;
				yr += dy;
				zr -= atan_rad[i];
			end else begin
				xr += dx;
				yr -= dy;
				zr += atan_rad[i];
			end
		end
		sn = flip ? -yr : yr;
		cs = flip ? -xr : xr;
	endtask

	task automatic predict_ecef(input logic signed [30:0] lat, input logic signed [31:0] lon,
			input logic signed [27:0] h, output ecef_t res);
		logic signed [63:0] slat, clat, slon, clon, wq, rq, nq, nh, nz, pq, hq;
		angle_sin_cos(longint'(lat), slat, clat);
		angle_sin_cos(longint'(lon), slon, clon);
		wq = ONE_Q61 - mul_rnd(ecc2_q61, mul_rnd(slat, slat, 61), 61);
		rq = ONE_Q61;
		for (int k = 0; k < 4; k++)
			rq = mul_rnd(rq, THREE_Q61 - mul_rnd(wq, mul_rnd(rq, rq, 61), 61), 62);
		nq = mul_rnd(SEMI_MAJOR_MM, rq, 37);
		hq = 64'(h) <<< 24;
		nh = nq + hq;
		nz = mul_rnd(nq, one_minus_ecc2, 61) + hq;
		pq = mul_rnd(nh, clat, 61);
		res.x = 34'(mul_rnd(pq, clon, 85));
		res.y = 34'(mul_rnd(pq, slon, 85));
		res.z = 34'(mul_rnd(nz, slat, 85));
	endtask

	task automatic report_mismatch(input string field, input logic signed [33:0] got,
			input logic signed [33:0] want);
		$display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
		errors++;
	endtask

	// one transfer on the input side; called right after a rising edge
	task automatic send_fix(input logic signed [30:0] lat, input logic signed [31:0] lon,
			input logic signed [27:0] h);
		ecef_t res;
		int    gap;
		gap = (tx_idle_en != 0 && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		latitude <= lat;
		longitude <= lon;
		height_mm <= h;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_ecef(lat, lon, h, res);
		ecef_expected.push_back(res);
		fixes_sent++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random(input int count);
		logic signed [30:0] lat;
		logic signed [31:0] lon;
		logic signed [27:0] h;
		repeat (count) begin
			if ($urandom_range(0, 4) == 0) begin
				lat = 31'($urandom());
				lon = 32'($urandom());
				h = 28'($urandom());
			end else begin
				lat = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
				lon = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
				h = 28'(longint'($urandom_range(0, 101000000)) - 1000000);
			end
			send_fix(lat, lon, h);
		end
	endtask

	task automatic test_field_extremes();
		send_fix(31'sd900000000, 32'sd0, 28'sd0);
		send_fix(-31'sd900000000, 32'sd0, 28'sd0);
		send_fix(31'sd0, 32'sd1800000000, 28'sd100000000);
		send_fix(31'sd0, -32'sd1800000000, -28'sd1000000);
		send_fix(31'sd0, 32'sd0, 28'sd0);
		send_fix(31'sd0, 32'sd900000000, 28'sd0);
		send_fix(31'sd0, -32'sd900000000, 28'sd0);
		send_fix(31'sd450000000, 32'sd450000000, 28'sd1234567);
		send_fix(31'h3FFFFFFF, 32'h7FFFFFFF, 28'h7FFFFFF);
		send_fix(31'sh40000000, 32'sh80000000, 28'sh8000000);
		send_fix(-31'sd1, -32'sd1, -28'sd1);
		drop_valid();
	endtask

	task automatic test_angle_folding();
		send_fix(31'sd900000001, 32'sd1800000001, 28'sd0);
		send_fix(-31'sd900000001, -32'sd1800000001, 28'sd0);
		send_fix(31'sd1073741823, 32'sd2147483647, 28'sd5000);
		send_fix(-31'sd1073741824, -32'sd2147483647, -28'sd5000);
		send_fix(31'sd1000000000, 32'sd1900000000, 28'sd0);
		send_fix(-31'sd1000000000, -32'sd1900000000, 28'sd0);
		drop_valid();
	endtask

	task automatic test_backpressure_fill();
		hold_cnt = HOLD_LEN;
		send_random(250);
		drop_valid();
	endtask

	task automatic test_drain_pause();
		wait (ecef_expected.size() == 0);
		repeat (20) @(posedge clk);
		send_random(50);
		drop_valid();
	endtask

	task automatic test_random_idle();
		send_random(700);
		drop_valid();
	endtask

	task automatic test_streaming();
		tx_idle_en = 0;
		rx_idle_en = 0;
		send_random(180);
		drop_valid();
	endtask

	initial begin
		out_stall = 1'b0;
		burst_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
			end else if (burst_cnt > 0) begin
				out_stall <= 1'b1;
				burst_cnt--;
			end else if (rx_idle_en != 0 && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				burst_cnt = $urandom_range(0, 10);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		ecef_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (ecef_expected.size() == 0) begin
				$display("%0t: result transfer with nothing expected", $time);
				errors++;
			end else begin
				want = ecef_expected.pop_front();
				if (ecef_x !== want.x) report_mismatch("ecef_x", ecef_x, want.x);
				if (ecef_y !== want.y) report_mismatch("ecef_y", ecef_y, want.y);
				if (ecef_z !== want.z) report_mismatch("ecef_z", ecef_z, want.z);
				fixes_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("%0t: timeout, no transfer for %0d cycles", $time, STALL_MAX);
			$display("geodetic_to_ecef_tb: done, errors");
			$finish;
		end
	end

	initial begin
		in_valid = 1'b0;
		latitude = '0;
		longitude = '0;
		height_mm = '0;
		arst_n = 1'b0;
		errors = 0;
		fixes_sent = 0;
		fixes_checked = 0;
		idle_cycles = 0;
		hold_cnt = 0;
		tx_idle_en = 1;
		rx_idle_en = 1;
		for (int i = 0; i < CORDIC_N; i++)
			atan_rad[i] = arctan_pow2(i);
		flat_q61 = $signed(64'(((128'd1 << 61) * 128'd1000000000 + 128'd149128611781)
			/ 128'd298257223563));
		ecc2_q61 = 2 * flat_q61 - mul_rnd(flat_q61, flat_q61, 61);
		one_minus_ecc2 = ONE_Q61 - ecc2_q61;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_angle_folding();
		test_backpressure_fill();
		test_drain_pause();
		test_random_idle();
		test_streaming();

		wait (ecef_expected.size() == 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (ecef_expected.size() != 0) begin
			$display("%0d results never arrived", ecef_expected.size());
			errors++;
		end
		$display("covered %0d fixes (poles, date line, folded angles, full-width bits),",
			fixes_sent);
		$display("%0d results checked under random and long output stalls", fixes_checked);
		if (errors == 0)
			$display("geodetic_to_ecef_tb: done, clean");
		else
			$display("geodetic_to_ecef_tb: done, errors");
		$finish;
	end

endmodule
